FILE: sv/erf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erf_pkg
// shared types and constants of the event rule filter: stream field layout,
// function codes, rule word codes and the store control bundle
// ----------------------------------------------------------------------------
package erf_pkg;

   // function codes carried in req_tuser
   localparam logic FUNC_WRITE    = 1'b0;
   localparam logic FUNC_CLASSIFY = 1'b1;

   // word codes inside one rule (low four address bits)
   localparam logic [3:0] WORD_ENABLE = 4'd0;
   localparam logic [3:0] WORD_EVENT  = 4'd1;
   localparam logic [3:0] WORD_PROC   = 4'd2;
   localparam logic [3:0] WORD_THREAD = 4'd3;
   localparam logic [3:0] WORD_USER   = 4'd4;
   localparam logic [3:0] WORD_PLEN   = 4'd5;
   localparam logic [3:0] WORD_NLEN   = 4'd6;
   localparam int         WORD_PREFIX = 7;

   // bytes carried by a classify transaction
   localparam int PATH_IN_BYTES = 24;
   localparam int CMD_IN_BYTES  = 16;

   // root directory character
   localparam logic [7:0] ROOT_CHAR = 8'h2F;

   // request tdata layout, lowest bit first
   localparam int REQ_ADDR_LSB  = 0;
   localparam int REQ_WDATA_LSB = 9;
   localparam int REQ_EVT_LSB   = 73;
   localparam int REQ_PID_LSB   = 105;
   localparam int REQ_TID_LSB   = 137;
   localparam int REQ_UID_LSB   = 169;
   localparam int REQ_NLO_LSB   = 201;
   localparam int REQ_NHI_LSB   = 265;
   localparam int REQ_P0_LSB    = 329;
   localparam int REQ_P1_LSB    = 393;
   localparam int REQ_P2_LSB    = 457;
   localparam int REQ_DATA_W    = 528;
   localparam int RSP_DATA_W    = 8;

   // control from the sequencer to the rule store
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } store_ctl_type;

endpackage

FILE: sv/erf_rule_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erf_rule_store
// rule table memories: word writes, clearing pass after reset and one
// registered rule read per cycle for the match unit
// ----------------------------------------------------------------------------
module erf_rule_store #(
   parameter int RULE_SLOTS   = 24,
   parameter int PREFIX_BYTES = 24,
   parameter int NAME_BYTES   = 16,
   localparam int IW  = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1,
   localparam int CW  = $clog2(RULE_SLOTS + 1),
   localparam int PW  = (PREFIX_BYTES + 7) / 8,
   localparam int NW  = (NAME_BYTES + 7) / 8,
   localparam int PLW = $clog2(PREFIX_BYTES + 1),
   localparam int NLW = $clog2(NAME_BYTES + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  erf_pkg::store_ctl_type ctl,
   input  logic [8:0]             wr_addr,
   input  logic [63:0]            wr_data,
   input  logic [IW-1:0]          rd_idx,
   output logic                   rule_en,
   output logic [31:0]            rule_evt,
   output logic [31:0]            rule_pid,
   output logic [31:0]            rule_tid,
   output logic [31:0]            rule_uid,
   output logic [PLW-1:0]         rule_plen,
   output logic [NLW-1:0]         rule_nlen,
   output logic [PW*64-1:0]       rule_pfx,
   output logic [NW*64-1:0]       rule_nam,
   output logic                   clr_busy
);
   import erf_pkg::*;

   localparam int PLN       = (PW > 1) ? $clog2(PW) : 1;
   localparam int NLN       = (NW > 1) ? $clog2(NW) : 1;
   localparam int WORD_NAME = WORD_PREFIX + PW;

   // rule table memories, one row per rule
   logic                    en_mem  [RULE_SLOTS];
   logic [31:0]             evt_mem [RULE_SLOTS];
   logic [31:0]             pid_mem [RULE_SLOTS];
   logic [31:0]             tid_mem [RULE_SLOTS];
   logic [31:0]             uid_mem [RULE_SLOTS];
   logic [PLW-1:0]          plen_mem[RULE_SLOTS];
   logic [NLW-1:0]          nlen_mem[RULE_SLOTS];
   logic [PW-1:0][63:0]     pfx_mem [RULE_SLOTS];
   logic [NW-1:0][63:0]     nam_mem [RULE_SLOTS];

   logic                    clr_busy_ff, clr_busy_in;
   logic [CW-1:0]           clr_idx_ff, clr_idx_in;

   logic                    en_ff;
   logic [31:0]             evt_ff, pid_ff, tid_ff, uid_ff;
   logic [PLW-1:0]          plen_ff;
   logic [NLW-1:0]          nlen_ff;
   logic [PW-1:0][63:0]     pfx_ff;
   logic [NW-1:0][63:0]     nam_ff;

   logic [4:0]              wr_rule;
   logic [3:0]              wr_word;
   logic [IW-1:0]           wr_idx;
   logic [31:0]             wr_word_ext;
   logic                    wr_ok;
   logic                    pfx_sel, nam_sel;
   logic [PLN-1:0]          pfx_lane;
   logic [NLN-1:0]          nam_lane;
   logic [PLW-1:0]          plen_sat;
   logic [NLW-1:0]          nlen_sat;

   // address decode and length saturation
   always_comb begin
      wr_rule     = wr_addr[8:4];
      wr_word     = wr_addr[3:0];
      wr_word_ext = {28'd0, wr_word};
      wr_idx      = IW'(wr_rule);
      wr_ok       = ctl.wr_en && ({27'd0, wr_rule} < RULE_SLOTS);
      pfx_sel     = (wr_word_ext >= WORD_PREFIX) && (wr_word_ext < WORD_NAME);
      nam_sel     = (wr_word_ext >= WORD_NAME) && (wr_word_ext < WORD_NAME + NW);
      pfx_lane    = PLN'(wr_word_ext - WORD_PREFIX);
      nam_lane    = NLN'(wr_word_ext - WORD_NAME);
      plen_sat    = (wr_data > 64'(PREFIX_BYTES)) ? PLW'(PREFIX_BYTES) : wr_data[PLW-1:0];
      nlen_sat    = (wr_data > 64'(NAME_BYTES)) ? NLW'(NAME_BYTES) : wr_data[NLW-1:0];
   end

   // clearing pass, one rule row per cycle
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_idx_in  = clr_idx_ff;
      if (clr_busy_ff) begin
         clr_idx_in = clr_idx_ff + CW'(1);
         if (clr_idx_ff == CW'(RULE_SLOTS - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_idx_ff  <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_idx_ff  <= clr_idx_in;
      end
   end

   // table writes: clear rows after reset, otherwise one word per transaction
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         en_mem[clr_idx_ff[IW-1:0]]   <= 1'b0;
         evt_mem[clr_idx_ff[IW-1:0]]  <= '0;
         pid_mem[clr_idx_ff[IW-1:0]]  <= '0;
         tid_mem[clr_idx_ff[IW-1:0]]  <= '0;
         uid_mem[clr_idx_ff[IW-1:0]]  <= '0;
         plen_mem[clr_idx_ff[IW-1:0]] <= '0;
         nlen_mem[clr_idx_ff[IW-1:0]] <= '0;
         pfx_mem[clr_idx_ff[IW-1:0]]  <= '0;
         nam_mem[clr_idx_ff[IW-1:0]]  <= '0;
      end else if (wr_ok) begin
         priority if (wr_word == WORD_ENABLE) begin
            en_mem[wr_idx] <= |wr_data;
         end else if (wr_word == WORD_EVENT) begin
            evt_mem[wr_idx] <= wr_data[31:0];
         end else if (wr_word == WORD_PROC) begin
            pid_mem[wr_idx] <= wr_data[31:0];
         end else if (wr_word == WORD_THREAD) begin
            tid_mem[wr_idx] <= wr_data[31:0];
         end else if (wr_word == WORD_USER) begin
            uid_mem[wr_idx] <= wr_data[31:0];
         end else if (wr_word == WORD_PLEN) begin
            plen_mem[wr_idx] <= plen_sat;
         end else if (wr_word == WORD_NLEN) begin
            nlen_mem[wr_idx] <= nlen_sat;
         end else if (pfx_sel) begin
            pfx_mem[wr_idx][pfx_lane] <= wr_data;
         end else if (nam_sel) begin
            nam_mem[wr_idx][nam_lane] <= wr_data;
         end else begin
            // unused words of a rule are dropped
         end
      end
   end

   // registered rule read
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         en_ff   <= en_mem[rd_idx];
         evt_ff  <= evt_mem[rd_idx];
         pid_ff  <= pid_mem[rd_idx];
         tid_ff  <= tid_mem[rd_idx];
         uid_ff  <= uid_mem[rd_idx];
         plen_ff <= plen_mem[rd_idx];
         nlen_ff <= nlen_mem[rd_idx];
         pfx_ff  <= pfx_mem[rd_idx];
         nam_ff  <= nam_mem[rd_idx];
      end
   end

   assign rule_en   = en_ff;
   assign rule_evt  = evt_ff;
   assign rule_pid  = pid_ff;
   assign rule_tid  = tid_ff;
   assign rule_uid  = uid_ff;
   assign rule_plen = plen_ff;
   assign rule_nlen = nlen_ff;
   assign rule_pfx  = pfx_ff;
   assign rule_nam  = nam_ff;
   assign clr_busy  = clr_busy_ff;

endmodule

FILE: sv/erf_rule_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erf_rule_match
// compare unit shared by all rules: checks one rule row against the held
// event (ids with wildcards, command name and filename prefix)
// ----------------------------------------------------------------------------
module erf_rule_match #(
   parameter int PREFIX_BYTES = 24,
   parameter int NAME_BYTES   = 16,
   localparam int PW  = (PREFIX_BYTES + 7) / 8,
   localparam int NW  = (NAME_BYTES + 7) / 8,
   localparam int PLW = $clog2(PREFIX_BYTES + 1),
   localparam int NLW = $clog2(NAME_BYTES + 1)
) (
   input  logic             rule_en,
   input  logic [31:0]      rule_evt,
   input  logic [31:0]      rule_pid,
   input  logic [31:0]      rule_tid,
   input  logic [31:0]      rule_uid,
   input  logic [PLW-1:0]   rule_plen,
   input  logic [NLW-1:0]   rule_nlen,
   input  logic [PW*64-1:0] rule_pfx,
   input  logic [NW*64-1:0] rule_nam,
   input  logic [31:0]      ev_evt,
   input  logic [31:0]      ev_pid,
   input  logic [31:0]      ev_tid,
   input  logic [31:0]      ev_uid,
   input  logic [127:0]     ev_name,
   input  logic [191:0]     ev_path,
   output logic             hit
);
   import erf_pkg::*;

   logic [PREFIX_BYTES-1:0] pfx_byte_ok;
   logic [NAME_BYTES-1:0]   nam_byte_ok;
   logic                    ids_ok, pfx_ok, nam_ok;

   // per-byte filename prefix compare, bytes past the carried path read zero
   for (genvar i = 0; i < PREFIX_BYTES; i++) begin : g_pfx
      logic [7:0] ev_b;
      logic [7:0] ru_b;
      if (i < PATH_IN_BYTES) begin : g_in
         assign ev_b = ev_path[8*i +: 8];
      end else begin : g_zero
         assign ev_b = 8'd0;
      end
      assign ru_b = rule_pfx[8*i +: 8];
      assign pfx_byte_ok[i] = (PLW'(i) >= rule_plen) || ((ev_b == ru_b) && (ev_b != 8'd0));
   end

   // per-byte command name compare
   for (genvar i = 0; i < NAME_BYTES; i++) begin : g_nam
      logic [7:0] ev_b;
      logic [7:0] ru_b;
      if (i < CMD_IN_BYTES) begin : g_in
         assign ev_b = ev_name[8*i +: 8];
      end else begin : g_zero
         assign ev_b = 8'd0;
      end
      assign ru_b = rule_nam[8*i +: 8];
      assign nam_byte_ok[i] = (NLW'(i) >= rule_nlen) || ((ev_b == ru_b) && (ev_b != 8'd0));
   end

   // combine; an empty filename matches only an empty prefix or the lone root prefix
   always_comb begin
      ids_ok = ((rule_evt == 32'd0) || (rule_evt == ev_evt)) &&
               ((rule_pid == 32'd0) || (rule_pid == ev_pid)) &&
               ((rule_tid == 32'd0) || (rule_tid == ev_tid)) &&
               ((rule_uid == 32'd0) || (rule_uid == ev_uid));
      nam_ok = &nam_byte_ok;
      if (rule_plen == '0) begin
         pfx_ok = 1'b1;
      end else if (ev_path[7:0] == 8'd0) begin
         pfx_ok = (rule_plen == PLW'(1)) && (rule_pfx[7:0] == ROOT_CHAR);
      end else begin
         pfx_ok = &pfx_byte_ok;
      end
      hit = rule_en && ids_ok && nam_ok && pfx_ok;
   end

endmodule

FILE: sv/event_rule_filter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_rule_filter_top
// rule table filter for system events: rule word loads and event classify
// ----------------------------------------------------------------------------
// Usage
//   req_* carries two kinds of transaction, selected by req_tuser: a rule word
//   write (loads one word of the rule table, no response) and an event
//   classify (one response on rsp_*, rsp_tdata[0] = allowed).
//   csr_wr_en/csr_wr_data set the number of leading rules that are checked;
//   write it only while the block is idle.
// Sequencing
//   a rule word write is taken while the sequencer is idle. A classify walks
//   the active rules one per cycle through a single compare unit fed by the
//   registered table read, then passes the drain and finish states; finish
//   loads the result into the output register behind rsp_tvalid and returns
//   to idle. With no active rules the classify goes straight to finish.
// Reset and stalls
//   after reset a clearing pass zeroes every table row, during which
//   req_tready is low. A response waits in the output register while
//   rsp_tready is low; rule writes are still taken, a classify finishes its
//   walk and then holds until the output register frees up.
// ----------------------------------------------------------------------------
module event_rule_filter_top #(
   parameter int RULE_SLOTS   = 24,
   parameter int PREFIX_BYTES = 24,
   parameter int NAME_BYTES   = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   // addr[8:0], word_data, evt_id, proc_id, thread_id, user_id,
   // name_lo, name_hi, path_0, path_1, path_2, zero fill
   input  logic [erf_pkg::REQ_DATA_W-1:0]   req_tdata,
   // func
   input  logic                             req_tuser,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // allowed, zero fill
   output logic [erf_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic                             csr_wr_en,
   input  logic [4:0]                       csr_wr_data
);
   import erf_pkg::*;

   localparam int IW  = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
   localparam int CW  = $clog2(RULE_SLOTS + 1);
   localparam int PW  = (PREFIX_BYTES + 7) / 8;
   localparam int NW  = (NAME_BYTES + 7) / 8;
   localparam int PLW = $clog2(PREFIX_BYTES + 1);
   localparam int NLW = $clog2(NAME_BYTES + 1);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_RUN    = 2'd1;
   localparam logic [1:0] ST_DRAIN  = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [CW-1:0]    idx_ff, idx_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [CW-1:0]    cnt_sat;
   logic             hit_ff, hit_in;
   logic             rd_vld_ff;
   logic             out_vld_ff, out_vld_in;
   logic             out_bit_ff, out_bit_in;
   logic [4:0]       active_ff;

   logic [31:0]      evt_ff, pid_ff, tid_ff, uid_ff;
   logic [127:0]     name_ff;
   logic [191:0]     path_ff;

   logic             req_acc, cls_acc, clr_busy, rule_hit;
   store_ctl_type    st_ctl;

   logic             rule_en;
   logic [31:0]      rule_evt, rule_pid, rule_tid, rule_uid;
   logic [PLW-1:0]   rule_plen;
   logic [NLW-1:0]   rule_nlen;
   logic [PW*64-1:0] rule_pfx;
   logic [NW*64-1:0] rule_nam;

   // handshake decode
   assign req_tready    = (state_ff == ST_IDLE) && !clr_busy;
   assign req_acc       = req_tvalid && req_tready;
   assign cls_acc       = req_acc && (req_tuser == FUNC_CLASSIFY);
   assign st_ctl.wr_en  = req_acc && (req_tuser == FUNC_WRITE);
   assign st_ctl.rd_en  = (state_ff == ST_RUN);
   assign cnt_sat       = ({27'd0, active_ff} > RULE_SLOTS) ? CW'(RULE_SLOTS) : CW'(active_ff);

   // rule table
   erf_rule_store #(
      .RULE_SLOTS   (RULE_SLOTS),
      .PREFIX_BYTES (PREFIX_BYTES),
      .NAME_BYTES   (NAME_BYTES)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .ctl       (st_ctl),
      .wr_addr   (req_tdata[REQ_ADDR_LSB +: 9]),
      .wr_data   (req_tdata[REQ_WDATA_LSB +: 64]),
      .rd_idx    (idx_ff[IW-1:0]),
      .rule_en   (rule_en),
      .rule_evt  (rule_evt),
      .rule_pid  (rule_pid),
      .rule_tid  (rule_tid),
      .rule_uid  (rule_uid),
      .rule_plen (rule_plen),
      .rule_nlen (rule_nlen),
      .rule_pfx  (rule_pfx),
      .rule_nam  (rule_nam),
      .clr_busy  (clr_busy)
   );

   // shared compare unit
   erf_rule_match #(
      .PREFIX_BYTES (PREFIX_BYTES),
      .NAME_BYTES   (NAME_BYTES)
   ) u_match (
      .rule_en   (rule_en),
      .rule_evt  (rule_evt),
      .rule_pid  (rule_pid),
      .rule_tid  (rule_tid),
      .rule_uid  (rule_uid),
      .rule_plen (rule_plen),
      .rule_nlen (rule_nlen),
      .rule_pfx  (rule_pfx),
      .rule_nam  (rule_nam),
      .ev_evt    (evt_ff),
      .ev_pid    (pid_ff),
      .ev_tid    (tid_ff),
      .ev_uid    (uid_ff),
      .ev_name   (name_ff),
      .ev_path   (path_ff),
      .hit       (rule_hit)
   );

   // sequencer
   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      cnt_in     = cnt_ff;
      hit_in     = hit_ff;
      out_vld_in = out_vld_ff;
      out_bit_in = out_bit_ff;
      if (rd_vld_ff && rule_hit) begin
         hit_in = 1'b1;
      end
      if (out_vld_ff && rsp_tready) begin
         out_vld_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (cls_acc) begin
               cnt_in = cnt_sat;
               idx_in = '0;
               if (cnt_sat == '0) begin
                  hit_in   = 1'b1;
                  state_in = ST_FINISH;
               end else begin
                  hit_in   = 1'b0;
                  state_in = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            idx_in = idx_ff + CW'(1);
            if (idx_ff == cnt_ff - CW'(1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!out_vld_ff || rsp_tready) begin
               out_vld_in = 1'b1;
               out_bit_in = hit_ff;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         idx_ff     <= '0;
         cnt_ff     <= '0;
         hit_ff     <= 1'b0;
         rd_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         active_ff  <= '0;
      end else begin
         state_ff   <= state_in;
         idx_ff     <= idx_in;
         cnt_ff     <= cnt_in;
         hit_ff     <= hit_in;
         rd_vld_ff  <= st_ctl.rd_en;
         out_vld_ff <= out_vld_in;
         if (csr_wr_en) begin
            active_ff <= csr_wr_data;
         end
      end
   end

   // result bit and held event fields
   always_ff @(posedge clock) begin
      out_bit_ff <= out_bit_in;
      if (cls_acc) begin
         evt_ff  <= req_tdata[REQ_EVT_LSB +: 32];
         pid_ff  <= req_tdata[REQ_PID_LSB +: 32];
         tid_ff  <= req_tdata[REQ_TID_LSB +: 32];
         uid_ff  <= req_tdata[REQ_UID_LSB +: 32];
         name_ff <= {req_tdata[REQ_NHI_LSB +: 64], req_tdata[REQ_NLO_LSB +: 64]};
         path_ff <= {req_tdata[REQ_P2_LSB +: 64], req_tdata[REQ_P1_LSB +: 64],
                     req_tdata[REQ_P0_LSB +: 64]};
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {(RSP_DATA_W - 1)'(0), out_bit_ff};

endmodule

FILE: sv/erf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erf_checker
// port-level checks of the event rule filter, bound to the top level
// ----------------------------------------------------------------------------
module erf_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           req_tuser,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [erf_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import erf_pkg::*;

   // table clearing keeps the request side closed right after reset
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("request accepted during table clearing");

   // a classify occupies the sequencer for at least the next cycle
   a_classify_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser == FUNC_CLASSIFY) |=> !req_tready)
      else $error("request accepted while a classify is in progress");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled response changed or dropped");

   // only the allowed bit may be set in a response
   a_rsp_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[RSP_DATA_W-1:1] == '0))
      else $error("response fill bits not zero");

endmodule

bind event_rule_filter_top erf_checker u_erf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

FILE: verif/tb_event_rule_filter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_event_rule_filter_top
// self-checking bench for the event rule filter: rule word loads and event
// classify transactions go in on req_*, allowed flags come back on rsp_*. a
// local copy of the rule table and active count predicts each flag in accept
// order. directed tests come first, then random traffic that loads whole rules
// and builds events from the loaded rules, under several idle/stall mixes and
// one long response hold-off.
// ----------------------------------------------------------------------------
module tb_event_rule_filter_top;
   import erf_pkg::*;

   localparam int SLOTS        = 24;
   localparam int PFX_BYTES    = 24;
   localparam int NM_BYTES     = 16;
   localparam int PFX_WORDS    = 3;
   localparam int NM_WORDS     = 2;
   localparam int WORD_NAME    = WORD_PREFIX + PFX_WORDS;
   localparam logic [3:0] WORD_SPARE = 4'd15;
   localparam int DRAIN_CYCLES = SLOTS + 8;
   localparam int HOLD_CYCLES  = 300;
   localparam int TIMEOUT_NS   = 10_000_000;
   localparam logic [63:0] TEXT_A = 64'h6161_6161_6161_6161;

   // one request transaction, unpacked view
   typedef struct packed {
      logic        func;
      logic [8:0]  addr;
      logic [63:0] wdata;
      logic [31:0] evt_id;
      logic [31:0] pid;
      logic [31:0] tid;
      logic [31:0] uid;
      logic [63:0] name_lo;
      logic [63:0] name_hi;
      logic [63:0] path_0;
      logic [63:0] path_1;
      logic [63:0] path_2;
   } filter_req_type;

   logic                  clock;
   logic                  reset;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tuser;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic                  csr_wr_en;
   logic [4:0]            csr_wr_data;

   // predicted rule table and active count
   bit          rule_on   [SLOTS];
   logic [31:0] rule_evt  [SLOTS];
   logic [31:0] rule_pid  [SLOTS];
   logic [31:0] rule_tid  [SLOTS];
   logic [31:0] rule_uid  [SLOTS];
   int          rule_plen [SLOTS];
   int          rule_nlen [SLOTS];
   logic [63:0] rule_pfx  [SLOTS][PFX_WORDS];
   logic [63:0] rule_nm   [SLOTS][NM_WORDS];
   int          active_cnt;

   logic allowed_q[$];
   int   mismatch_cnt;
   int   send_idle_pct;
   int   recv_stall_pct;
   int   hold_left;

   event_rule_filter_top #(
      .RULE_SLOTS   (SLOTS),
      .PREFIX_BYTES (PFX_BYTES),
      .NAME_BYTES   (NM_BYTES)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // hard stop
   initial begin
      #(TIMEOUT_NS);
      $display("DONE: errors detected");
      $finish;
   end

   // ------------------------------------------------------------------------
   // error reporting
   // ------------------------------------------------------------------------
   task automatic flag_mismatch(input string msg);
      mismatch_cnt++;
      if (mismatch_cnt <= 10)
         $display("%0t ns: %s", $time, msg);
   endtask

   // ------------------------------------------------------------------------
   // rule table prediction
   // ------------------------------------------------------------------------
   function automatic int checked_rules();
      return (active_cnt > SLOTS) ? SLOTS : active_cnt;
   endfunction

   function automatic void store_rule_word(logic [8:0] addr, logic [63:0] data);
      int r;
      int w;
      r = int'(addr[8:4]);
      w = int'(addr[3:0]);
      // rows past the table and spare words are dropped
      if (r >= SLOTS)
         return;
      if (w == WORD_ENABLE)
         rule_on[r] = (data != 64'd0);
      else if (w == WORD_EVENT)
         rule_evt[r] = data[31:0];
      else if (w == WORD_PROC)
         rule_pid[r] = data[31:0];
      else if (w == WORD_THREAD)
         rule_tid[r] = data[31:0];
      else if (w == WORD_USER)
         rule_uid[r] = data[31:0];
      else if (w == WORD_PLEN)
         rule_plen[r] = (data > PFX_BYTES) ? PFX_BYTES : int'(data[4:0]);
      else if (w == WORD_NLEN)
         rule_nlen[r] = (data > NM_BYTES) ? NM_BYTES : int'(data[4:0]);
      else if (w >= WORD_PREFIX && w < WORD_NAME)
         rule_pfx[r][w - WORD_PREFIX] = data;
      else if (w >= WORD_NAME && w < WORD_NAME + NM_WORDS)
         rule_nm[r][w - WORD_NAME] = data;
   endfunction

   // every byte inside the length must match and be nonzero
   function automatic bit name_match(filter_req_type q, int r);
      logic [127:0] cmd;
      logic [127:0] want;
      int           i;
      bit           ok;
      cmd  = {q.name_hi, q.name_lo};
      want = {rule_nm[r][1], rule_nm[r][0]};
      ok   = 1'b1;
      for (i = 0; i < rule_nlen[r]; i++)
         if (cmd[8*i +: 8] != want[8*i +: 8] || cmd[8*i +: 8] == 8'h00)
            ok = 1'b0;
      return ok;
   endfunction

   // empty filename only passes an empty prefix or a lone root prefix
   function automatic bit prefix_match(filter_req_type q, int r);
      logic [191:0] pth;
      logic [191:0] want;
      int           i;
      bit           ok;
      pth  = {q.path_2, q.path_1, q.path_0};
      want = {rule_pfx[r][2], rule_pfx[r][1], rule_pfx[r][0]};
      ok   = 1'b1;
      if (rule_plen[r] == 0)
         return 1'b1;
      if (pth[7:0] == 8'h00)
         return (rule_plen[r] == 1) && (want[7:0] == ROOT_CHAR);
      for (i = 0; i < rule_plen[r]; i++)
         if (pth[8*i +: 8] != want[8*i +: 8] || pth[8*i +: 8] == 8'h00)
            ok = 1'b0;
      return ok;
   endfunction

   function automatic logic predict_allowed(filter_req_type q);
      int   r;
      logic hit;
      hit = 1'b0;
      if (checked_rules() == 0)
         return 1'b1;
      for (r = 0; r < checked_rules(); r++)
         if (rule_on[r] &&
             (rule_evt[r] == 0 || rule_evt[r] == q.evt_id) &&
             (rule_pid[r] == 0 || rule_pid[r] == q.pid) &&
             (rule_tid[r] == 0 || rule_tid[r] == q.tid) &&
             (rule_uid[r] == 0 || rule_uid[r] == q.uid) &&
             name_match(q, r) && prefix_match(q, r))
            hit = 1'b1;
      return hit;
   endfunction

   // ------------------------------------------------------------------------
   // transaction builders
   // ------------------------------------------------------------------------
   function automatic logic [REQ_DATA_W-1:0] pack_req(filter_req_type q);
      logic [REQ_DATA_W-1:0] d;
      d = '0;
      d[REQ_ADDR_LSB  +: 9]  = q.addr;
      d[REQ_WDATA_LSB +: 64] = q.wdata;
      d[REQ_EVT_LSB   +: 32] = q.evt_id;
      d[REQ_PID_LSB   +: 32] = q.pid;
      d[REQ_TID_LSB   +: 32] = q.tid;
      d[REQ_UID_LSB   +: 32] = q.uid;
      d[REQ_NLO_LSB   +: 64] = q.name_lo;
      d[REQ_NHI_LSB   +: 64] = q.name_hi;
      d[REQ_P0_LSB    +: 64] = q.path_0;
      d[REQ_P1_LSB    +: 64] = q.path_1;
      d[REQ_P2_LSB    +: 64] = q.path_2;
      return d;
   endfunction

   function automatic logic [8:0] rule_addr(int r, logic [3:0] w);
      return {r[4:0], w};
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // unused fields carry random bits
   function automatic filter_req_type rule_write(logic [8:0] addr, logic [63:0] data);
      filter_req_type q;
      q.func    = FUNC_WRITE;
      q.addr    = addr;
      q.wdata   = data;
      q.evt_id  = $urandom;
      q.pid     = $urandom;
      q.tid     = $urandom;
      q.uid     = $urandom;
      q.name_lo = rand64();
      q.name_hi = rand64();
      q.path_0  = rand64();
      q.path_1  = rand64();
      q.path_2  = rand64();
      return q;
   endfunction

   function automatic filter_req_type blank_event();
      filter_req_type q;
      q      = '0;
      q.func = FUNC_CLASSIFY;
      return q;
   endfunction

   function automatic logic [31:0] pick_id();
      case ($urandom_range(3))
         0:       return 32'd1;
         1:       return 32'd2;
         2:       return 32'hFFFF_FFFF;
         default: return 32'h8000_0000;
      endcase
   endfunction

   // mostly root, 'a' and 'b' so that prefixes line up
   function automatic logic [63:0] rand_text();
      logic [63:0] v;
      int          i;
      for (i = 0; i < 8; i++)
         case ($urandom_range(15))
            0, 1, 2:    v[8*i +: 8] = ROOT_CHAR;
            3, 4, 5, 6: v[8*i +: 8] = 8'h61;
            7, 8, 9:    v[8*i +: 8] = 8'h62;
            10:         v[8*i +: 8] = 8'h00;
            default:    v[8*i +: 8] = 8'($urandom);
         endcase
      return v;
   endfunction

   function automatic logic [63:0] rand_word_data(logic [3:0] w);
      logic [63:0] v;
      int          sel;
      sel = $urandom_range(9);
      v   = rand64();
      if (w == WORD_ENABLE) begin
         if (sel < 2)
            v = '0;
         else if (sel < 6)
            v = 64'd1 << $urandom_range(63);
      end else if (w >= WORD_EVENT && w <= WORD_USER) begin
         if (sel < 5)
            v = '0;
         else if (sel < 8)
            v = {$urandom, pick_id()};
      end else if (w == WORD_PLEN || w == WORD_NLEN) begin
         if (sel < 6)
            v = 64'($urandom_range(3));
         else if (sel < 9)
            v = 64'($urandom_range(30));
      end else if (sel < 8) begin
         v = rand_text();
      end
      return v;
   endfunction

   function automatic logic [31:0] pick_field(logic [31:0] rv);
      case ($urandom_range(9))
         0, 1:    return $urandom;
         2, 3:    return pick_id();
         default: return (rv != 0) ? rv : $urandom;
      endcase
   endfunction

   // event aimed at one checked rule, with random misses mixed in
   function automatic filter_req_type rand_event();
      filter_req_type q;
      logic [127:0]   nm;
      logic [191:0]   pth;
      int             r;
      int             i;
      int             sel;
      r        = $urandom_range(((checked_rules() == 0) ? SLOTS : checked_rules()) - 1);
      q        = rule_write(9'($urandom), rand64());
      q.func   = FUNC_CLASSIFY;
      q.evt_id = pick_field(rule_evt[r]);
      q.pid    = pick_field(rule_pid[r]);
      q.tid    = pick_field(rule_tid[r]);
      q.uid    = pick_field(rule_uid[r]);
      // command name
      nm = {rule_nm[r][1], rule_nm[r][0]};
      for (i = rule_nlen[r]; i < NM_BYTES; i++)
         nm[8*i +: 8] = 8'($urandom);
      sel = $urandom_range(9);
      if (sel == 0)
         nm = {rand64(), rand64()};
      else if (sel < 3 && rule_nlen[r] > 0)
         nm[8*$urandom_range(rule_nlen[r] - 1) +: 8] = 8'($urandom);
      // filename
      pth = {rule_pfx[r][2], rule_pfx[r][1], rule_pfx[r][0]};
      for (i = rule_plen[r]; i < PFX_BYTES; i++)
         pth[8*i +: 8] = 8'($urandom);
      sel = $urandom_range(9);
      if (sel == 0)
         pth = {rand64(), rand64(), rand64()};
      else if (sel == 1)
         pth[7:0] = 8'h00;
      else if (sel < 4 && rule_plen[r] > 0)
         pth[8*$urandom_range(rule_plen[r] - 1) +: 8] = 8'($urandom);
      {q.name_hi, q.name_lo}          = nm;
      {q.path_2, q.path_1, q.path_0} = pth;
      return q;
   endfunction

   // ------------------------------------------------------------------------
   // driving
   // ------------------------------------------------------------------------
   // offers one transaction and updates the prediction once it is taken
   task automatic send_item(input filter_req_type q);
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat (($urandom_range(3) == 0) ? $urandom_range(2, 30) : 1)
            @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= q.func;
      req_tdata  <= pack_req(q);
      do @(posedge clock); while (!req_tready);
      if (q.func == FUNC_WRITE)
         store_rule_word(q.addr, q.wdata);
      else
         allowed_q.push_back(predict_allowed(q));
   endtask

   task automatic write_word(input logic [8:0] addr, input logic [63:0] data);
      send_item(rule_write(addr, data));
   endtask

   task automatic load_rule(input int r);
      int w;
      for (w = 0; w < WORD_NAME + NM_WORDS; w++)
         write_word(rule_addr(r, w[3:0]), rand_word_data(w[3:0]));
   endtask

   // idle the request side, drain responses, then write the count
   task automatic set_active_rules(input logic [4:0] cnt);
      req_tvalid <= 1'b0;
      while (allowed_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= cnt;
      @(posedge clock);
      active_cnt = int'(cnt);
      csr_wr_en  <= 1'b0;
   endtask

   task automatic set_idling(input int s_pct, input int r_pct);
      send_idle_pct  = s_pct;
      recv_stall_pct = r_pct;
   endtask

   // response side ready, with random stalls and the long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // response checking against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (allowed_q.size() == 0)
            flag_mismatch($sformatf("unexpected response, allowed %0b", rsp_tdata[0]));
         else if (rsp_tdata[0] !== allowed_q[0])
            flag_mismatch($sformatf("allowed mismatch: expected %0b got %0b",
                                    allowed_q[0], rsp_tdata[0]));
         if (allowed_q.size() != 0)
            void'(allowed_q.pop_front());
      end
   end

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   // zero count allows all, a disabled rule blocks all
   task automatic test_count_zero();
      filter_req_type q;
      set_active_rules(5'd0);
      q      = rule_write(9'($urandom), rand64());
      q.func = FUNC_CLASSIFY;
      send_item(q);
      set_active_rules(5'd1);
      send_item(blank_event());
   endtask

   // enable from any bit, numeric match and wildcard, low word kept
   task automatic test_numeric_fields();
      filter_req_type q;
      write_word(rule_addr(0, WORD_ENABLE), 64'h8000_0000_0000_0000);
      send_item(blank_event());
      write_word(rule_addr(0, WORD_EVENT), 64'hFFFF_FFFF_1234_5678);
      q        = blank_event();
      q.evt_id = 32'h1234_5678;
      send_item(q);
      q.evt_id = 32'hFFFF_FFFF;
      send_item(q);
      write_word(rule_addr(0, WORD_EVENT), 64'd0);
      write_word(rule_addr(0, WORD_USER), 64'h0000_0000_FFFF_FFFF);
      q     = blank_event();
      q.uid = 32'hFFFF_FFFF;
      send_item(q);
      write_word(rule_addr(0, WORD_USER), 64'd0);
   endtask

   // root prefix on empty filename, saturated lengths, zero byte in range
   task automatic test_string_fields();
      filter_req_type q;
      write_word(rule_addr(0, WORD_PLEN), 64'd1);
      write_word(rule_addr(0, 4'(WORD_PREFIX)), {56'd0, ROOT_CHAR});
      send_item(blank_event());
      q        = blank_event();
      q.path_0 = {48'd0, 8'h61, ROOT_CHAR};
      send_item(q);
      write_word(rule_addr(0, WORD_PLEN), '1);
      send_item(q);
      write_word(rule_addr(0, WORD_PLEN), 64'd0);
      write_word(rule_addr(0, WORD_NLEN), 64'd17);
      write_word(rule_addr(0, 4'(WORD_NAME)), TEXT_A);
      write_word(rule_addr(0, 4'(WORD_NAME + 1)), TEXT_A);
      q         = blank_event();
      q.name_lo = TEXT_A;
      q.name_hi = TEXT_A;
      send_item(q);
      q.name_hi[63:56] = 8'h00;
      send_item(q);
   endtask

   // writes past the table or to spare words leave the rules alone
   task automatic test_ignored_writes();
      filter_req_type q;
      write_word(rule_addr(SLOTS, WORD_ENABLE), '1);
      write_word(rule_addr(0, WORD_SPARE), '1);
      q         = blank_event();
      q.name_lo = TEXT_A;
      q.name_hi = TEXT_A;
      send_item(q);
   endtask

   // responses held off long enough for the block to stop taking input
   task automatic test_backpressure();
      int i;
      set_active_rules(5'd24);
      set_idling(0, 0);
      hold_left <= HOLD_CYCLES;
      for (i = 0; i < 40; i++)
         if (i % 4 == 3)
            write_word(9'($urandom), rand64());
         else
            send_item(rand_event());
   endtask

   // whole rule loads, stray word writes and aimed events
   task automatic test_random_traffic(input int s_pct, input int r_pct,
                                      input logic [4:0] cnt, input int n_items);
      int sent;
      int sel;
      int i;
      logic [8:0] addr;
      set_active_rules(cnt);
      set_idling(s_pct, r_pct);
      sent = 0;
      for (i = 0; i < 3; i++)
         load_rule($urandom_range(((checked_rules() == 0) ? SLOTS : checked_rules()) - 1));
      while (sent < n_items) begin
         sel = $urandom_range(99);
         if (sel < 6) begin
            load_rule($urandom_range(((checked_rules() == 0) ? SLOTS : checked_rules()) - 1));
            sent += WORD_NAME + NM_WORDS;
         end else if (sel < 22) begin
            addr = 9'($urandom);
            write_word(addr, ($urandom_range(3) == 0) ? rand64() : rand_word_data(addr[3:0]));
            sent++;
         end else begin
            send_item(rand_event());
            sent++;
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------------
   initial begin
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tuser    = FUNC_WRITE;
      req_tdata    = '0;
      rsp_tready   = 1'b0;
      csr_wr_en    = 1'b0;
      csr_wr_data  = '0;
      hold_left    = 0;
      mismatch_cnt = 0;
      active_cnt   = 0;
      set_idling(0, 0);
      for (int r = 0; r < SLOTS; r++) begin
         rule_on[r]   = 1'b0;
         rule_evt[r]  = '0;
         rule_pid[r]  = '0;
         rule_tid[r]  = '0;
         rule_uid[r]  = '0;
         rule_plen[r] = 0;
         rule_nlen[r] = 0;
         for (int w = 0; w < PFX_WORDS; w++)
            rule_pfx[r][w] = '0;
         for (int w = 0; w < NM_WORDS; w++)
            rule_nm[r][w] = '0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_count_zero();
      test_numeric_fields();
      test_string_fields();
      test_ignored_writes();
      test_backpressure();
      test_random_traffic(0, 0, 5'd24, 350);
      test_random_traffic(46, 0, 5'd31, 350);
      test_random_traffic(0, 46, 5'($urandom_range(2, 23)), 350);
      test_random_traffic(22, 22, 5'd25, 350);
      test_random_traffic(0, 0, 5'd1, 250);

      // let the last responses and any trailing writes finish
      req_tvalid <= 1'b0;
      while (allowed_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_cnt == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
